[design/sensor_frame_crc_decoder_macros.svh]
// Assertion macros for the sensor frame CRC decoder.
// Used by sensor_frame_crc_decoder.sv; no other dependencies.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef SENSOR_FRAME_CRC_DECODER_MACROS_SVH
`define SENSOR_FRAME_CRC_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define SFCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sfcd assertion failed");

// Next-cycle implication, disabled during reset
`define SFCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sfcd assertion failed");

`else

`define SFCD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SFCD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[design/sfcd_pkg.sv]
// Package for the sensor frame CRC decoder: frame constants, codes, CRC-8 step.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sfcd_pkg;

	// Frame layout: four data bytes then the CRC byte
	localparam int unsigned POS_W       = 3;
	localparam logic [POS_W-1:0] LAST_POS = 3'd4;

	// CRC-8, MSB first, no final xor
	localparam logic [7:0] CRC_INIT  = 8'hFF;
	localparam logic [7:0] CRC_POLY  = 8'h31;
	localparam logic [7:0] READY_BIT = 8'h01;

	typedef enum logic [1:0] {
		CODE_OK        = 2'd0,
		CODE_BUS       = 2'd1,
		CODE_CRC       = 2'd2,
		CODE_NOT_READY = 2'd3
	} result_code_t;

	typedef enum logic [1:0] {
		KIND_CONC    = 2'd0,
		KIND_VERSION = 2'd1,
		KIND_RESIST  = 2'd2,
		KIND_SPARE   = 2'd3
	} reg_kind_t;

	// One byte through the CRC-8 register, eight shift steps unrolled
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[design/sfcd_if.sv]
// Valid/ready channel interfaces for the sensor frame CRC decoder.
// Depends on sfcd_pkg for the result code type.
`timescale 1ns / 1ps
`default_nettype none

// Received bytes, one request per byte
interface sfcd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic [1:0] reg_kind;
	logic       bus_error;

	modport source (output valid, output rx_byte, output reg_kind, output bus_error,
		input ready);
	modport sink (input valid, input rx_byte, input reg_kind, input bus_error,
		output ready);
endinterface

// Decoded frame results, one request per frame
interface sfcd_result_if;
	import sfcd_pkg::*;
	logic         valid;
	logic         ready;
	result_code_t result_code;
	logic [31:0]  value;
	logic [31:0]  raw_data;
	logic [7:0]   sensor_status;
	logic         crc_ok;
	logic         data_ready;

	modport source (output valid, output result_code, output value, output raw_data,
		output sensor_status, output crc_ok, output data_ready, input ready);
	modport sink (input valid, input result_code, input value, input raw_data,
		input sensor_status, input crc_ok, input data_ready, output ready);
endinterface

`default_nettype wire

[design/sensor_frame_crc_decoder.sv]
// An accepted byte is registered in the input stage, then in the frame state; a fifth byte's
// result goes to the result register. Throughput: one byte per cycle, back to back, unless a
// fifth byte waits on a full result register; set by the unrolled CRC-8 step between stages.
// Reset (arst_n low, asynchronous): byte position 0, CRC 0xFF, data and bus flag cleared,
// no request pending in either stage.
// Depends on sfcd_pkg, sfcd_if and sensor_frame_crc_decoder_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "sensor_frame_crc_decoder_macros.svh"

module sensor_frame_crc_decoder (
	input  wire logic     clk,
	input  wire logic     arst_n,
	sfcd_byte_if.sink     frame,
	sfcd_result_if.source result
);
	import sfcd_pkg::*;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic [1:0] kind_s1;
	logic       berr_s1;

	// Frame state
	logic [POS_W-1:0] pos_q;
	logic [7:0]       crc_q;
	logic [31:0]      shift_q;
	logic             berr_q;

	// Result register
	logic         res_valid_q;
	result_code_t res_code_q;
	logic [31:0]  res_value_q;
	logic [31:0]  res_raw_q;
	logic [7:0]   res_status_q;
	logic         res_crc_ok_q;
	logic         res_ready_q;

	logic         last_byte;
	logic         out_free;
	logic         s1_fire;
	logic         in_fire;
	logic [7:0]   crc_next;
	logic         berr_next;
	logic [7:0]   status;
	logic         ready_bit_clr;
	logic         crc_good;
	logic [23:0]  resist_raw;
	logic [31:0]  value_next;
	result_code_t code_next;

	// Handshake: a byte leaves stage 1 unless it is a fifth byte facing a full result register
	assign last_byte   = (pos_q >= LAST_POS);
	assign out_free    = !res_valid_q || result.ready;
	assign s1_fire     = valid_s1 && (!last_byte || out_free);
	assign frame.ready = !valid_s1 || s1_fire;
	assign in_fire     = frame.valid && frame.ready;

	// Running CRC and sticky bus fault
	assign crc_next  = crc8_byte(crc_q, byte_s1);
	assign berr_next = berr_q | berr_s1;

	// Frame decode
	assign status        = shift_q[31:24];
	assign ready_bit_clr = ((status & READY_BIT) == 8'h00);
	assign crc_good      = (crc_next == 8'h00);
	assign resist_raw    = shift_q[31:8];

	always_comb begin
		unique case (reg_kind_t'(kind_s1))
			KIND_CONC:   value_next = {8'h00, shift_q[23:0]};
			// times ten as x*8 + x*2
			KIND_RESIST: value_next = {5'd0, resist_raw, 3'd0} + {7'd0, resist_raw, 1'b0};
			default:     value_next = shift_q;
		endcase
	end

	// First fault wins: bus, then CRC, then not ready
	always_comb begin
		if (berr_next) begin
			code_next = CODE_BUS;
		end else if (!crc_good) begin
			code_next = CODE_CRC;
		end else if ((reg_kind_t'(kind_s1) == KIND_CONC) && !ready_bit_clr) begin
			code_next = CODE_NOT_READY;
		end else begin
			code_next = CODE_OK;
		end
	end

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= frame.rx_byte;
			kind_s1 <= frame.reg_kind;
			berr_s1 <= frame.bus_error;
		end
	end

	// Frame state: advance on each byte, restart after the CRC byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			crc_q   <= CRC_INIT;
			shift_q <= '0;
			berr_q  <= 1'b0;
		end else if (s1_fire) begin
			if (last_byte) begin
				pos_q   <= '0;
				crc_q   <= CRC_INIT;
				shift_q <= '0;
				berr_q  <= 1'b0;
			end else begin
				pos_q   <= pos_q + 1'b1;
				crc_q   <= crc_next;
				shift_q <= {shift_q[23:0], byte_s1};
				berr_q  <= berr_next;
			end
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_fire && last_byte) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (s1_fire && last_byte) begin
			res_code_q   <= code_next;
			res_value_q  <= value_next;
			res_raw_q    <= shift_q;
			res_status_q <= status;
			res_crc_ok_q <= crc_good;
			res_ready_q  <= ready_bit_clr;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.result_code   = res_code_q;
	assign result.value         = res_value_q;
	assign result.raw_data      = res_raw_q;
	assign result.sensor_status = res_status_q;
	assign result.crc_ok        = res_crc_ok_q;
	assign result.data_ready    = res_ready_q;

	// Checks
	`SFCD_ASSERT_NOW(a_pos_range, clk, arst_n, 1'b1, pos_q <= LAST_POS)
	`SFCD_ASSERT_NEXT(a_frame_end_result, clk, arst_n, s1_fire && last_byte, res_valid_q)
	`SFCD_ASSERT_NEXT(a_frame_restart, clk, arst_n, s1_fire && last_byte,
		(pos_q == '0) && (crc_q == CRC_INIT) && !berr_q)
	`SFCD_ASSERT_NOW(a_ok_needs_crc, clk, arst_n, res_valid_q && (res_code_q == CODE_OK),
		res_crc_ok_q)

endmodule

`default_nettype wire

[bench/sensor_frame_crc_decoder_test.sv]
// Self-checking bench for sensor_frame_crc_decoder: five-byte frames in, decoded results out.
// Depends on sfcd_pkg and the channel interfaces in sfcd_if; predicts every result itself.
`timescale 1ns / 1ps

module sensor_frame_crc_decoder_test;
	import sfcd_pkg::*;

	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 12;
	localparam int RANDOM_FRAMES  = 340;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 8;

	// What the byte driver does with one queue slot
	typedef enum logic [1:0] {
		SLOT_BYTE,
		SLOT_IDLE,
		SLOT_DRAIN
	} slot_kind_t;

	typedef struct {
		slot_kind_t what;
		logic [7:0] rx_byte;
		reg_kind_t  reg_kind;
		logic       bus_error;
	} byte_slot_t;

	typedef struct {
		result_code_t code;
		logic [31:0]  value;
		logic [31:0]  raw_data;
		logic [7:0]   status;
		logic         crc_ok;
		logic         data_ready;
	} decoded_frame_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Byte channel drive
	logic       byte_valid = 1'b0;
	logic [7:0] byte_data = 8'h00;
	reg_kind_t  byte_kind = KIND_CONC;
	logic       byte_err = 1'b0;
	logic       byte_taken = 1'b0;

	// Result channel drive
	logic result_ready = 1'b0;
	int   stall_left = 0;
	int   calm_left = 0;

	byte_slot_t     pending_bytes[$];
	decoded_frame_t expected_frames[$];
	int             failures = 0;
	int             stuck_cycles = 0;

	// Frame tracker of the predictor
	logic [2:0]  frame_pos = 3'd0;
	logic [7:0]  frame_crc = CRC_INIT;
	logic [31:0] frame_word = 32'h0;
	logic        frame_bus_fault = 1'b0;

	sfcd_byte_if   frame_ch ();
	sfcd_result_if result_ch ();

	assign frame_ch.valid     = byte_valid;
	assign frame_ch.rx_byte   = byte_data;
	assign frame_ch.reg_kind  = byte_kind;
	assign frame_ch.bus_error = byte_err;
	assign result_ch.ready    = result_ready;

	sensor_frame_crc_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_ch),
		.result (result_ch)
	);

	always #CLK_HALF clk = ~clk;

	// CRC-8 over one byte, MSB first
	function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] r;
		r = acc ^ b;
		repeat (8) begin
			r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		end
		return r;
	endfunction

	// Mostly short idles, a few long ones
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic add_idle(input int n);
		byte_slot_t s;
		s.what = SLOT_IDLE;
		s.rx_byte = 8'h00;
		s.reg_kind = KIND_CONC;
		s.bus_error = 1'b0;
		repeat (n) pending_bytes.push_back(s);
	endtask

	task automatic add_drain();
		byte_slot_t s;
		s.what = SLOT_DRAIN;
		s.rx_byte = 8'h00;
		s.reg_kind = KIND_CONC;
		s.bus_error = 1'b0;
		pending_bytes.push_back(s);
	endtask

	// Four data bytes plus CRC byte; crc_flip of zero gives a valid frame
	task automatic queue_frame(input logic [31:0] data, input reg_kind_t kind,
			input logic [4:0] err_mask, input logic [7:0] crc_flip, input bit calm);
		logic [7:0] acc;
		byte_slot_t s;
		acc = CRC_INIT;
		for (int i = 0; i < 5; i++) begin
			if (i < 4) begin
				s.rx_byte = data[31 - 8 * i -: 8];
				acc = crc_step(acc, s.rx_byte);
			end else begin
				s.rx_byte = acc ^ crc_flip;
			end
			if (!calm) add_idle(draw_gap());
			s.what = SLOT_BYTE;
			// kind is only looked at on the CRC byte; the rest is noise
			s.reg_kind = (i == 4) ? kind : reg_kind_t'($urandom_range(0, 3));
			s.bus_error = err_mask[i];
			pending_bytes.push_back(s);
		end
	endtask

	// Predictor: advance the frame on one accepted request
	task automatic predict_byte(input logic [7:0] b, input reg_kind_t kind, input logic berr);
		decoded_frame_t d;
		logic [31:0] ohms;
		frame_crc = crc_step(frame_crc, b);
		frame_bus_fault = frame_bus_fault | berr;
		if (frame_pos < 3'd4) begin
			frame_word = {frame_word[23:0], b};
			frame_pos = frame_pos + 3'd1;
		end else begin
			d.raw_data = frame_word;
			d.status = frame_word[31:24];
			d.data_ready = ~frame_word[24];
			d.crc_ok = (frame_crc == 8'h00);
			ohms = {8'h00, frame_word[31:8]};
			case (kind)
				KIND_CONC:   d.value = {8'h00, frame_word[23:0]};
				KIND_RESIST: d.value = ohms * 32'd10;
				default:     d.value = frame_word;
			endcase
			// first fault wins: bus, then CRC, then not ready
			if (frame_bus_fault) d.code = CODE_BUS;
			else if (!d.crc_ok) d.code = CODE_CRC;
			else if (kind == KIND_CONC && !d.data_ready) d.code = CODE_NOT_READY;
			else d.code = CODE_OK;
			expected_frames.push_back(d);
			frame_pos = 3'd0;
			frame_crc = CRC_INIT;
			frame_word = 32'h0;
			frame_bus_fault = 1'b0;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			failures++;
		end
	endtask

	// Byte driver: next slot once the current request is gone
	always @(negedge clk) begin : drive_bytes
		byte_slot_t nxt;
		if (!arst_n) begin
			byte_valid <= 1'b0;
		end else if (!byte_valid || byte_taken) begin
			if (pending_bytes.size() == 0) begin
				byte_valid <= 1'b0;
			end else if (pending_bytes[0].what == SLOT_DRAIN && expected_frames.size() != 0) begin
				byte_valid <= 1'b0;
			end else begin
				nxt = pending_bytes.pop_front();
				if (nxt.what == SLOT_BYTE) begin
					byte_valid <= 1'b1;
					byte_data <= nxt.rx_byte;
					byte_kind <= nxt.reg_kind;
					byte_err <= nxt.bus_error;
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// Result sink: random stalls with calm stretches
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (stall_left > 0) begin
			result_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			result_ready <= 1'b1;
			if (calm_left > 0) calm_left <= calm_left - 1;
			else if ($urandom_range(0, 3) == 0) stall_left <= draw_gap();
			else if ($urandom_range(0, 49) == 0) calm_left <= $urandom_range(50, 300);
		end
	end

	// Monitor: predict on accepted bytes, compare accepted results
	always @(posedge clk) begin : watch_channels
		decoded_frame_t want;
		logic byte_fire;
		logic result_fire;
		byte_fire = frame_ch.valid && frame_ch.ready;
		result_fire = result_ch.valid && result_ch.ready;
		byte_taken <= arst_n && byte_fire;
		if (arst_n) begin
			if (byte_fire) predict_byte(frame_ch.rx_byte, reg_kind_t'(frame_ch.reg_kind),
				frame_ch.bus_error);
			if (result_fire) begin
				if (expected_frames.size() == 0) begin
					$error("result with no frame pending: code %0d value 0x%0h",
						result_ch.result_code, result_ch.value);
					failures++;
				end else begin
					want = expected_frames.pop_front();
					check_field("result_code", 32'(want.code), 32'(result_ch.result_code));
					check_field("value", want.value, result_ch.value);
					check_field("raw_data", want.raw_data, result_ch.raw_data);
					check_field("sensor_status", 32'(want.status), 32'(result_ch.sensor_status));
					check_field("crc_ok", 32'(want.crc_ok), 32'(result_ch.crc_ok));
					check_field("data_ready", 32'(want.data_ready), 32'(result_ch.data_ready));
				end
			end
			stuck_cycles <= (byte_fire || result_fire) ? 0 : stuck_cycles + 1;
		end
	end

	// Watchdog on a stalled run
	initial begin
		wait (stuck_cycles >= WATCHDOG_LIMIT);
		$display("sensor_frame_crc_decoder regression: fail");
		$finish;
	end

	// Stimulus, reset and end of run
	initial begin : run_frames
		logic [31:0] data;
		reg_kind_t   kind;
		logic [4:0]  mask;
		logic [7:0]  flip;
		bit          calm;
		calm = 1'b0;

		// Directed: extremes, every kind, each fault and the fault order
		queue_frame(32'h0000_0000, KIND_CONC, 5'b00000, 8'h00, 1'b1);
		queue_frame(32'hFFFF_FFFF, KIND_RESIST, 5'b00000, 8'h00, 1'b0);
		queue_frame(32'h0112_3456, KIND_CONC, 5'b00000, 8'h00, 1'b0);
		add_drain();
		queue_frame(32'h00AB_CDEF, KIND_SPARE, 5'b00000, 8'h01, 1'b0);
		// bus error only on the CRC byte, with a bad CRC too: bus wins
		queue_frame(32'h8180_7F01, KIND_VERSION, 5'b10000, 8'h80, 1'b1);

		// Random frames, mostly well formed
		for (int f = 0; f < RANDOM_FRAMES; f++) begin
			if (f % 60 == 30) add_drain();
			if ($urandom_range(0, 9) == 0) calm = !calm;
			data = $urandom;
			kind = reg_kind_t'($urandom_range(0, 3));
			mask = ($urandom_range(0, 6) == 0) ? 5'($urandom) : 5'b00000;
			flip = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
			queue_frame(data, kind, mask, flip, calm);
		end

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		while (pending_bytes.size() != 0 || byte_valid) @(posedge clk);
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (failures == 0) begin
			$display("sensor_frame_crc_decoder regression: pass");
		end else begin
			$display("sensor_frame_crc_decoder regression: fail");
		end
		$finish;
	end

endmodule
